// ===== rtl/core/heliocentric_to_jacobi_defines.svh =====
// Assertion macros shared by the checker of heliocentric_to_jacobi.
// No dependencies.
`ifndef HELIOCENTRIC_TO_JACOBI_DEFINES_SVH
`define HELIOCENTRIC_TO_JACOBI_DEFINES_SVH

// Same-cycle implication.
`define HJC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define HJC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/hjc_pkg.sv =====
// Shared constants, types and helpers for heliocentric_to_jacobi.
// No dependencies.
`timescale 1ns / 1ps

package hjc_pkg;
	localparam int AXES       = 6;
	localparam int MASS_W     = 24;
	localparam int COORD_W    = 32;
	localparam int CMASS_W    = 32;
	localparam int SUM_W      = 64;
	localparam int PROD_W     = MASS_W + 1 + COORD_W;
	localparam int QCLAMP_W   = 35;
	localparam logic [SUM_W-1:0] MEAN_CLAMP = 64'd1 << 34;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic clear;
		logic start;
	} lane_ctrl_t;

	function automatic coord_t sat_coord(input logic signed [COORD_W+4:0] v);
		logic signed [COORD_W+4:0] hi;
		logic signed [COORD_W+4:0] lo;
		hi = (COORD_W+5)'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = -hi - (COORD_W+5)'(1);
		if (v > hi)
			return coord_t'(hi[COORD_W-1:0]);
		else if (v < lo)
			return coord_t'(lo[COORD_W-1:0]);
		else
			return coord_t'(v[COORD_W-1:0]);
	endfunction
endpackage

// ===== rtl/core/hjc_body_if.sv =====
// Input channel: one body per transfer.
// Depends on hjc_pkg.
`timescale 1ns / 1ps

interface hjc_body_if;
	import hjc_pkg::*;
	logic                valid;
	logic                ready;
	logic                first_body;
	logic [MASS_W-1:0]   body_mass;
	coord_t              pos_x;
	coord_t              pos_y;
	coord_t              pos_z;
	coord_t              vel_x;
	coord_t              vel_y;
	coord_t              vel_z;

	modport source (output valid, first_body, body_mass, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, input ready);
	modport sink (input valid, first_body, body_mass, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, output ready);
endinterface

// ===== rtl/core/hjc_coord_if.sv =====
// Output channel: one Jacobi coordinate set per transfer.
// Depends on hjc_pkg.
`timescale 1ns / 1ps

interface hjc_coord_if;
	import hjc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t jac_x;
	coord_t jac_y;
	coord_t jac_z;
	coord_t jac_vx;
	coord_t jac_vy;
	coord_t jac_vz;

	modport source (output valid, jac_x, jac_y, jac_z, jac_vx, jac_vy, jac_vz,
		input ready);
	modport sink (input valid, jac_x, jac_y, jac_z, jac_vx, jac_vy, jac_vz,
		output ready);
endinterface

// ===== rtl/core/hjc_lane.sv =====
// One axis lane: weighted-sum accumulator, bit-serial divider, subtract and MAC.
// Depends on hjc_pkg.
`timescale 1ns / 1ps

module hjc_lane import hjc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic [CMASS_W-1:0] divisor,
	input  logic [MASS_W-1:0]  mass,
	input  coord_t             h,
	output coord_t             res,
	output logic               done
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_ACC} state_t;

	localparam int CNT_W = $clog2(SUM_W);

	state_t                     state_q;
	logic signed [SUM_W-1:0]    ws_q;
	logic [SUM_W-1:0]           dvd_q;
	logic [CMASS_W:0]           rem_q;
	logic [CMASS_W-1:0]         div_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic                       zero_q;
	logic [MASS_W-1:0]          mass_q;
	coord_t                     h_q;
	coord_t                     res_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       done_q;

	logic [CMASS_W:0]           trial;
	logic                       ge;
	logic [QCLAMP_W-1:0]        qc;
	logic signed [COORD_W+4:0]  mean;
	logic signed [COORD_W+4:0]  diff;
	logic signed [SUM_W:0]      acc;

	always_comb begin
		trial = {rem_q[CMASS_W-1:0], dvd_q[SUM_W-1]};
		ge    = trial >= {1'b0, div_q};
		qc    = (dvd_q > MEAN_CLAMP) ? MEAN_CLAMP[QCLAMP_W-1:0] : dvd_q[QCLAMP_W-1:0];
		mean  = zero_q ? '0 : (neg_q ? -signed'({2'b00, qc}) : signed'({2'b00, qc}));
		diff  = {{5{h_q[COORD_W-1]}}, h_q} - mean;
		acc   = {ws_q[SUM_W-1], ws_q} + (SUM_W+1)'(prod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ws_q    <= '0;
			done_q  <= 1'b0;
			dvd_q   <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			zero_q  <= 1'b1;
			mass_q  <= '0;
			h_q     <= '0;
			res_q   <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (ctrl.clear) begin
						ws_q <= '0;
					end else if (ctrl.start) begin
						neg_q   <= ws_q[SUM_W-1];
						dvd_q   <= ws_q[SUM_W-1] ? SUM_W'(-ws_q) : SUM_W'(ws_q);
						rem_q   <= '0;
						div_q   <= divisor;
						zero_q  <= (divisor == '0);
						mass_q  <= mass;
						h_q     <= h;
						cnt_q   <= CNT_W'(SUM_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? trial - {1'b0, div_q} : trial;
					dvd_q <= {dvd_q[SUM_W-2:0], ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= S_MUL;
				end
				S_MUL: begin
					res_q   <= sat_coord(diff);
					prod_q  <= signed'({1'b0, mass_q}) * h_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (acc[SUM_W] != acc[SUM_W-1])
						ws_q <= acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
							: {1'b0, {(SUM_W-1){1'b1}}};
					else
						ws_q <= acc[SUM_W-1:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res  = res_q;
	assign done = done_q;
endmodule

// ===== rtl/core/heliocentric_to_jacobi.sv =====
// An orbiting body's result passes through the 64-step divider, subtract, MAC and a handoff to
// the output register; a central body's result (all zero) is loaded straight into that register.
// No new body is taken until the last result is in the output register, so output stalls hold
// the input too; six lanes divide bit-serially in parallel, one quotient bit per cycle each.
// Reset: arst_n clears cumulative mass, all weighted sums and the output register.
// Depends on hjc_pkg, hjc_body_if, hjc_coord_if, hjc_lane.
`timescale 1ns / 1ps

module heliocentric_to_jacobi import hjc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hjc_body_if.sink    bodies,
	hjc_coord_if.source coords
);
	logic [CMASS_W-1:0] cm_q;
	logic               busy_q;
	logic               pend_q;
	logic               zero_q;
	logic               ov_q;
	coord_t             jac_q [AXES];

	logic               in_xfer;
	logic               load;
	lane_ctrl_t         ctrl;
	coord_t             hv    [AXES];
	coord_t             res   [AXES];
	logic [AXES-1:0]    done;
	logic [CMASS_W:0]   cm_sum;

	assign bodies.ready = !busy_q && !pend_q;
	assign in_xfer      = bodies.valid && bodies.ready;
	assign ctrl.clear   = in_xfer && bodies.first_body;
	assign ctrl.start   = in_xfer && !bodies.first_body;
	assign load         = pend_q && (!ov_q || coords.ready);
	assign cm_sum       = {1'b0, cm_q} + (CMASS_W+1)'(bodies.body_mass);

	assign hv[0] = bodies.pos_x;
	assign hv[1] = bodies.pos_y;
	assign hv[2] = bodies.pos_z;
	assign hv[3] = bodies.vel_x;
	assign hv[4] = bodies.vel_y;
	assign hv[5] = bodies.vel_z;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		hjc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.divisor (cm_q),
			.mass    (bodies.body_mass),
			.h       (hv[a]),
			.res     (res[a]),
			.done    (done[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q   <= '0;
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			zero_q <= 1'b0;
			ov_q   <= 1'b0;
			for (int a = 0; a < AXES; a++)
				jac_q[a] <= '0;
		end else begin
			if (ctrl.clear) begin
				cm_q   <= CMASS_W'(bodies.body_mass);
				pend_q <= 1'b1;
				zero_q <= 1'b1;
			end else if (ctrl.start) begin
				cm_q   <= cm_sum[CMASS_W] ? '1 : cm_sum[CMASS_W-1:0];
				busy_q <= 1'b1;
				zero_q <= 1'b0;
			end
			if (busy_q && &done) begin
				busy_q <= 1'b0;
				pend_q <= 1'b1;
			end
			if (load) begin
				pend_q <= 1'b0;
				ov_q   <= 1'b1;
				for (int a = 0; a < AXES; a++)
					jac_q[a] <= zero_q ? '0 : res[a];
			end else if (coords.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign coords.valid  = ov_q;
	assign coords.jac_x  = jac_q[0];
	assign coords.jac_y  = jac_q[1];
	assign coords.jac_z  = jac_q[2];
	assign coords.jac_vx = jac_q[3];
	assign coords.jac_vy = jac_q[4];
	assign coords.jac_vz = jac_q[5];
endmodule

// ===== rtl/core/hjc_checker.sv =====
// Port-level assertions for heliocentric_to_jacobi, bound to the top level.
// Depends on hjc_pkg and heliocentric_to_jacobi_defines.svh.
`timescale 1ns / 1ps
`include "heliocentric_to_jacobi_defines.svh"

module hjc_checker import hjc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   in_first,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t jac_x,
	input coord_t jac_vz
);
	`HJC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`HJC_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(jac_x) && $stable(jac_vz))
	`HJC_ASSERT_NOW(a_central_zero, clk, arst_n, in_valid && in_ready && in_first && !out_valid, ##2 (out_valid && jac_x == '0 && jac_vz == '0))
	`HJC_ASSERT_NEXT(a_orbit_not_early, clk, arst_n, in_valid && in_ready && !in_first && !out_valid, !out_valid)
endmodule

bind heliocentric_to_jacobi hjc_checker u_hjc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (bodies.valid),
	.in_ready  (bodies.ready),
	.in_first  (bodies.first_body),
	.out_valid (coords.valid),
	.out_ready (coords.ready),
	.jac_x     (coords.jac_x),
	.jac_vz    (coords.jac_vz)
);
